>>> sv/i2a_pkg.sv
package i2a_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int IN_WIDTH = 32;
  localparam int NUM_CELLS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W = $clog2(NUM_CELLS + 1);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [3:0] DEC_LIMIT = 4'd10;
  localparam logic [3:0] DEC_ADJ_MIN = 4'd5;
  localparam logic [3:0] DEC_ADJ = 4'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_CONVERT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic dec;
  } cell_ctrl_t;

  function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
    logic [7:0] res;
    if (d < DEC_LIMIT) begin
      res = CHAR_ZERO + {4'd0, d};
    end else begin
      res = CHAR_A + {4'd0, d - DEC_LIMIT};
    end
    return res;
  endfunction

endpackage

>>> sv/integer_to_ascii_digits.sv
// Binary to ASCII text converter, decimal or uppercase hexadecimal.
// Input: pulse start with value_bits, is_signed and radix_select while busy
// is low; the transaction is taken at that edge and busy rises next cycle.
// Output: characters on ascii_char, marked by char_valid, most significant
// first, one per cycle once the digits begin (the skip state lies between
// the '-' and the first digit); last_char marks the final character. A
// negative signed value gives a leading '-' and then the digits of its
// magnitude. Conversion runs through a row of 4-bit digit cells (shift and
// add-3 in decimal, plain nibble shift in hex): the value is shifted in bit
// by bit, the sign is sent if negative, up to 9 leading zero cells are
// skipped, and then the characters are emitted. Skipped cells and digit
// characters always add up to the 10 cells, whatever the digit count.
// The next start is taken once busy is low; the final character is still
// on the output for that one cycle.
// Reset (rst, synchronous) returns to idle and drops any pending text.
// The receiver cannot stall: each character is on the ports for one cycle.
module integer_to_ascii_digits (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [i2a_pkg::IN_WIDTH-1:0] value_bits,
  input  logic                         is_signed,
  input  logic                         radix_select,
  output logic                         char_valid,
  output logic [7:0]                   ascii_char,
  output logic                         last_char
);

  localparam int W = i2a_pkg::VALUE_WIDTH;
  localparam int N = i2a_pkg::NUM_CELLS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONVERT,
    S_SIGN,
    S_SKIP,
    S_EMIT
  } state_t;

  state_t state;
  logic [W-1:0] mag;
  logic [i2a_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic [i2a_pkg::DIG_CNT_W-1:0] dig_cnt;
  logic negative;
  logic hex;

  logic [W-1:0] value;
  logic [W-1:0] value_mag;
  logic neg_in;
  logic accept;
  logic skip_zero;
  i2a_pkg::cell_ctrl_t ctrl;
  logic [3:0] cell_digit [N];
  logic cell_carry [N];
  logic [3:0] top_digit;

  assign value = value_bits[W-1:0];
  assign neg_in = is_signed & value[W-1];
  assign value_mag = neg_in ? (~value + {{(W-1){1'b0}}, 1'b1}) : value;
  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign top_digit = cell_digit[N-1];
  assign skip_zero = (top_digit == 4'd0) && (dig_cnt > i2a_pkg::DIG_CNT_W'(1));

  always_comb begin
    ctrl.dec = !hex;
    ctrl.op = i2a_pkg::CELL_HOLD;
    unique case (state)
      S_IDLE:    ctrl.op = accept ? i2a_pkg::CELL_CLEAR : i2a_pkg::CELL_HOLD;
      S_CONVERT: ctrl.op = i2a_pkg::CELL_CONVERT;
      S_SIGN:    ctrl.op = i2a_pkg::CELL_HOLD;
      S_SKIP:    ctrl.op = skip_zero ? i2a_pkg::CELL_SHIFT : i2a_pkg::CELL_HOLD;
      S_EMIT:    ctrl.op = i2a_pkg::CELL_SHIFT;
      default:   ctrl.op = i2a_pkg::CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      i2a_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .shift_in  (mag[W-1]),
        .digit_in  (4'd0),
        .digit     (cell_digit[i]),
        .carry_out (cell_carry[i])
      );
    end else begin : g_rest
      i2a_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .shift_in  (cell_carry[i-1]),
        .digit_in  (cell_digit[i-1]),
        .digit     (cell_digit[i]),
        .carry_out (cell_carry[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      char_valid <= 1'b0;
      last_char <= 1'b0;
    end else begin
      char_valid <= 1'b0;
      last_char <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mag <= value_mag;
            negative <= neg_in;
            hex <= radix_select;
            bit_cnt <= i2a_pkg::BIT_CNT_W'(W - 1);
            state <= S_CONVERT;
          end
        end
        S_CONVERT: begin
          mag <= {mag[W-2:0], 1'b0};
          bit_cnt <= bit_cnt - i2a_pkg::BIT_CNT_W'(1);
          dig_cnt <= i2a_pkg::DIG_CNT_W'(N);
          if (bit_cnt == '0) begin
            state <= negative ? S_SIGN : S_SKIP;
          end
        end
        S_SIGN: begin
          char_valid <= 1'b1;
          ascii_char <= i2a_pkg::CHAR_MINUS;
          state <= S_SKIP;
        end
        S_SKIP: begin
          if (skip_zero) begin
            dig_cnt <= dig_cnt - i2a_pkg::DIG_CNT_W'(1);
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          char_valid <= 1'b1;
          ascii_char <= i2a_pkg::digit_to_ascii(top_digit);
          last_char <= (dig_cnt == i2a_pkg::DIG_CNT_W'(1));
          dig_cnt <= dig_cnt - i2a_pkg::DIG_CNT_W'(1);
          if (dig_cnt == i2a_pkg::DIG_CNT_W'(1)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> ($past(state) == S_SIGN || $past(state) == S_EMIT))
    else $error("character strobe outside sign or emit");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    last_char |-> char_valid)
    else $error("last marker without character");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (char_valid && last_char) |-> !busy)
    else $error("still busy after last character");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy did not rise after start");

  a_emit_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (dig_cnt != '0))
    else $error("emit with no digits left");

endmodule

>>> sv/i2a_cell.sv
module i2a_cell (
  input  logic                clk,
  input  i2a_pkg::cell_ctrl_t ctrl,
  input  logic                shift_in,
  input  logic [3:0]          digit_in,
  output logic [3:0]          digit,
  output logic                carry_out
);

  logic [3:0] adjusted;

  always_comb begin
    if (ctrl.dec && digit >= i2a_pkg::DEC_ADJ_MIN) begin
      adjusted = digit + i2a_pkg::DEC_ADJ;
    end else begin
      adjusted = digit;
    end
  end

  assign carry_out = adjusted[3];

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      i2a_pkg::CELL_HOLD:    digit <= digit;
      i2a_pkg::CELL_CLEAR:   digit <= 4'd0;
      i2a_pkg::CELL_CONVERT: digit <= {adjusted[2:0], shift_in};
      i2a_pkg::CELL_SHIFT:   digit <= digit_in;
      default:               digit <= digit;
    endcase
  end

endmodule

>>> verif/tb_integer_to_ascii_digits.sv
`timescale 1ns / 100ps

module tb_integer_to_ascii_digits;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 200;
  localparam int MAX_GAP = 19;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_REPORTS = 10;
  localparam int TIMEOUT_NS = 2_000_000;
  localparam int NUM_DIRECTED = 24;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam int DEC_BASE = 10;
  localparam int HEX_BASE = 16;

  localparam logic READ_UNSIGNED = 1'b0;
  localparam logic READ_SIGNED = 1'b1;
  localparam logic BASE_TEN = 1'b0;
  localparam logic BASE_SIXTEEN = 1'b1;

  localparam logic [i2a_pkg::IN_WIDTH-1:0] MIN_NEG = {1'b1, {(i2a_pkg::IN_WIDTH-1){1'b0}}};
  localparam logic [i2a_pkg::IN_WIDTH-1:0] MAX_POS = {1'b0, {(i2a_pkg::IN_WIDTH-1){1'b1}}};
  localparam logic [i2a_pkg::IN_WIDTH-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [7:0] code;
    logic last;
  } text_char_t;

  typedef struct {
    logic [i2a_pkg::IN_WIDTH-1:0] value;
    logic sgn;
    logic radix;
    string text;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [i2a_pkg::IN_WIDTH-1:0] value_bits = '0;
  logic is_signed = 1'b0;
  logic radix_select = 1'b0;
  logic char_valid;
  logic [7:0] ascii_char;
  logic last_char;

  text_char_t pending_chars[$];
  int mismatch_count = 0;

  // empty text: expected characters come from the predictor
  stim_row_t dir_rows [NUM_DIRECTED] = '{
    '{32'h0000_0000, READ_UNSIGNED, BASE_TEN,     "0"},
    '{32'h0000_0000, READ_UNSIGNED, BASE_SIXTEEN, "0"},
    '{32'h0000_0000, READ_SIGNED,   BASE_TEN,     "0"},
    '{ALL_ONES,      READ_UNSIGNED, BASE_TEN,     "4294967295"},
    '{ALL_ONES,      READ_UNSIGNED, BASE_SIXTEEN, "FFFFFFFF"},
    '{ALL_ONES,      READ_SIGNED,   BASE_TEN,     "-1"},
    '{ALL_ONES,      READ_SIGNED,   BASE_SIXTEEN, "-1"},
    '{MIN_NEG,       READ_SIGNED,   BASE_TEN,     "-2147483648"},
    '{MIN_NEG,       READ_SIGNED,   BASE_SIXTEEN, "-80000000"},
    '{MIN_NEG,       READ_UNSIGNED, BASE_TEN,     "2147483648"},
    '{MAX_POS,       READ_SIGNED,   BASE_TEN,     "2147483647"},
    '{MAX_POS,       READ_SIGNED,   BASE_SIXTEEN, "7FFFFFFF"},
    '{32'd9,         READ_UNSIGNED, BASE_TEN,     "9"},
    '{32'd10,        READ_UNSIGNED, BASE_TEN,     "10"},
    '{32'd15,        READ_UNSIGNED, BASE_SIXTEEN, "F"},
    '{32'd16,        READ_UNSIGNED, BASE_SIXTEEN, "10"},
    '{32'hABCD_EF01, READ_UNSIGNED, BASE_SIXTEEN, "ABCDEF01"},
    '{32'h1234_5678, READ_SIGNED,   BASE_SIXTEEN, "12345678"},
    '{32'hFFFF_FFF6, READ_SIGNED,   BASE_TEN,     "-10"},
    '{32'd1,         READ_SIGNED,   BASE_SIXTEEN, "1"},
    '{32'd1_000_000_000, READ_UNSIGNED, BASE_TEN, "1000000000"},
    '{32'd999_999_999,   READ_UNSIGNED, BASE_TEN, ""},
    '{32'hDEAD_BEEF, READ_SIGNED,   BASE_TEN,     ""},
    '{32'hCAFE_F00D, READ_SIGNED,   BASE_SIXTEEN, ""}
  };

  integer_to_ascii_digits u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .value_bits(value_bits),
    .is_signed(is_signed),
    .radix_select(radix_select),
    .char_valid(char_valid),
    .ascii_char(ascii_char),
    .last_char(last_char)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endfunction

  function automatic void queue_text(input logic [7:0] text[$]);
    text_char_t c;
    foreach (text[i]) begin
      c.code = text[i];
      c.last = (i == text.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic void predict_text(input logic [i2a_pkg::IN_WIDTH-1:0] v, input logic sgn,
                                       input logic radix);
    logic [i2a_pkg::VALUE_WIDTH-1:0] mag;
    logic [i2a_pkg::VALUE_WIDTH-1:0] base;
    logic [3:0] digit;
    logic [7:0] text[$];
    logic negative;
    mag = v[i2a_pkg::VALUE_WIDTH-1:0];
    negative = (sgn == READ_SIGNED) && mag[i2a_pkg::VALUE_WIDTH-1];
    // two's complement of the minimum wraps to 2^(width-1), the wanted magnitude
    if (negative) mag = -mag;
    base = i2a_pkg::VALUE_WIDTH'((radix == BASE_SIXTEEN) ? HEX_BASE : DEC_BASE);
    do begin
      digit = 4'(mag % base);
      if (digit < DEC_BASE) text.push_front(ASCII_ZERO + 8'(digit));
      else text.push_front(ASCII_UPPER_A + 8'(digit - DEC_BASE));
      mag = mag / base;
    end while (mag != 0);
    if (negative) text.push_front(ASCII_MINUS);
    queue_text(text);
  endfunction

  function automatic void expect_typed(input string s);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    queue_text(text);
  endfunction

  function automatic logic [i2a_pkg::IN_WIDTH-1:0] pick_value();
    logic [i2a_pkg::IN_WIDTH-1:0] v;
    logic [i2a_pkg::IN_WIDTH-1:0] p;
    int k;
    p = 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom();
      4, 5: v = $urandom_range(0, 99);
      6: v = '0 - i2a_pkg::IN_WIDTH'($urandom_range(1, 100));
      7: begin
        if ($urandom_range(0, 1)) v = MIN_NEG + $urandom_range(0, 3);
        else v = MAX_POS - $urandom_range(0, 3);
      end
      8: v = $urandom() >> $urandom_range(0, i2a_pkg::IN_WIDTH - 1);
      default: begin
        if ($urandom_range(0, 1)) begin
          k = $urandom_range(1, 9);
          repeat (k) p = p * DEC_BASE;
        end else begin
          k = $urandom_range(1, 7);
          repeat (k) p = p * HEX_BASE;
        end
        v = p + $urandom_range(0, 2) - 1;
      end
    endcase
    return v;
  endfunction

  task automatic send_value(input logic [i2a_pkg::IN_WIDTH-1:0] v, input logic sgn,
                            input logic radix, input string text, input bit drain_first,
                            input bit no_gaps);
    int gap;
    bit from_idle;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    from_idle = 1'($urandom_range(0, 1));
    if (drain_first || gap != 0) begin
      start <= 1'b0;
      if (drain_first) begin
        do @(posedge clk); while (pending_chars.size() != 0);
      end
      if (from_idle && gap != 0) begin
        do @(posedge clk); while (busy);
      end
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value_bits <= v;
    is_signed <= sgn;
    radix_select <= radix;
    do @(posedge clk); while (busy);
    if (text.len() == 0) predict_text(v, sgn, radix);
    else expect_typed(text);
  endtask

  always @(posedge clk) begin
    text_char_t want;
    if (!rst && char_valid) begin
      if (pending_chars.size() == 0) begin
        note_mismatch($sformatf("unexpected char %h last %b", ascii_char, last_char));
      end else begin
        want = pending_chars.pop_front();
        if (ascii_char !== want.code) begin
          note_mismatch($sformatf("ascii_char exp %h got %h", want.code, ascii_char));
        end
        if (last_char !== want.last) begin
          note_mismatch($sformatf("last_char exp %b got %b (char %h)", want.last, last_char,
                                  want.code));
        end
      end
    end
  end

  initial begin
    int n;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      send_value(dir_rows[i].value, dir_rows[i].sgn, dir_rows[i].radix, dir_rows[i].text,
                 1'b0, (i % 8) < 3);
    end
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      send_value(pick_value(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), "",
                 (n % 64) == 0, (n % 50) >= 40);
    end
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("integer_to_ascii_digits regression: pass");
    end else begin
      $display("integer_to_ascii_digits regression: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("integer_to_ascii_digits regression: fail");
    $finish;
  end

endmodule
